### hw/rtl/iofg_pkg.sv
// ---------------------------------------------------------------------------
// iofg_pkg
// Shared types and constants of the IP option field generator.
// ---------------------------------------------------------------------------
package iofg_pkg;

    localparam logic [6:0] TYPE_MASK    = 7'h7f;
    localparam logic [6:0] T_EOOL       = 7'h00;
    localparam logic [6:0] T_NOP        = 7'h01;
    localparam logic [6:0] T_TS         = 7'h44;
    localparam logic [6:0] T_UNASSIGNED = 7'h5d;
    localparam logic [6:0] T_EXPERIM    = 7'h5e;

    localparam logic [5:0] TS_LEN     = 6'd36;
    localparam logic [7:0] TS_POINTER = 8'd5;
    localparam logic [7:0] TS_FLAGS   = 8'h03;
    localparam logic [5:0] PAD_STEP   = 6'd4;
    localparam logic [5:0] PAD_ROOM   = 6'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE = 2'd2;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_TS     = 2'd1;
    localparam logic [1:0] KIND_PAD    = 2'd2;

    localparam int Q_DEPTH = 2;

    // one classified request, as queued between front and back
    typedef struct packed {
        logic [7:0] tbyte;
        logic [5:0] len;
        logic [1:0] status;
        logic [1:0] kind;
        logic       one_shot;   // single result: error or size-only
    } desc_t;

endpackage

### hw/rtl/iofg_front.sv
// ---------------------------------------------------------------------------
// iofg_front
// Classifies an option request into a descriptor for the emit sequencer.
// ---------------------------------------------------------------------------
module iofg_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_option_byte,
    input  logic [5:0]         s_section_offset,
    input  logic [5:0]         s_space_left,
    input  logic               s_size_only,
    output logic               push,
    output iofg_pkg::desc_t    push_desc,
    input  logic               q_ready
);
    import iofg_pkg::*;

    logic [6:0] key;
    logic [5:0] pad_base;
    logic [5:0] pad_len;
    logic [5:0] len;
    logic [1:0] status;
    logic [1:0] kind;

    assign key      = s_option_byte[6:0] & TYPE_MASK;
    assign pad_base = PAD_STEP - {4'd0, s_section_offset[1:0]};
    assign pad_len  = (pad_base <= 6'd2 && s_space_left >= PAD_ROOM)
                    ? pad_base + PAD_STEP : pad_base;

    always_comb begin
        len    = 6'd0;
        status = ST_OK;
        kind   = KIND_SINGLE;
        priority if (key == T_EOOL || key == T_NOP) begin
            len = 6'd1;
            if (s_space_left < 6'd1) status = ST_NO_SPACE;
        end else if (key == T_TS) begin
            kind = KIND_TS;
            len  = TS_LEN;
            if (s_space_left < TS_LEN) status = ST_NO_SPACE;
        end else if (key == T_UNASSIGNED || key == T_EXPERIM) begin
            kind = KIND_PAD;
            len  = pad_len;
            if (s_space_left < 6'd2 || pad_len < 6'd2 || pad_len > s_space_left)
                status = ST_NO_SPACE;
        end else begin
            status = ST_BAD_TYPE;
        end
    end

    assign s_ready = q_ready;
    assign push    = s_valid && q_ready;

    always_comb begin
        push_desc.tbyte    = s_option_byte;
        push_desc.len      = (status == ST_OK) ? len : 6'd0;
        push_desc.status   = status;
        push_desc.kind     = kind;
        push_desc.one_shot = (status != ST_OK) || s_size_only;
    end

endmodule

### hw/rtl/iofg_queue.sv
// ---------------------------------------------------------------------------
// iofg_queue
// Short descriptor queue between classifier and emit sequencer.
// ---------------------------------------------------------------------------
module iofg_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  iofg_pkg::desc_t    push_desc,
    output logic               q_ready,
    input  logic               pop,
    output logic               q_valid,
    output iofg_pkg::desc_t    q_desc
);
    import iofg_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam logic [PW:0] FULL = (PW + 1)'(Q_DEPTH);

    desc_t       mem_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg, count_next;

    assign q_ready = (count_reg != FULL);
    assign q_valid = (count_reg != '0);
    assign q_desc  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_desc;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= FULL)
        else $error("queue count over depth");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

### hw/rtl/iofg_back.sv
// ---------------------------------------------------------------------------
// iofg_back
// Emit sequencer: walks a descriptor one option byte per word.
// ---------------------------------------------------------------------------
module iofg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  iofg_pkg::desc_t    q_desc,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last_byte,
    output logic [1:0]         m_status,
    output logic [5:0]         m_option_length
);
    import iofg_pkg::*;

    logic [5:0] idx_reg;
    logic       m_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [1:0] status_reg;
    logic [5:0] len_reg;

    logic       load;
    logic       last_next;
    logic [7:0] byte_next;

    assign load      = q_valid && (!m_valid_reg || m_ready);
    assign last_next = q_desc.one_shot || (idx_reg + 6'd1 == q_desc.len);
    assign pop       = load && last_next;

    always_comb begin
        byte_next = 8'd0;
        if (q_desc.one_shot) begin
            byte_next = 8'd0;
        end else if (idx_reg == 6'd0) begin
            byte_next = q_desc.tbyte;
        end else begin
            unique case (q_desc.kind)
                KIND_TS: begin
                    priority if (idx_reg == 6'd1) byte_next = {2'b00, TS_LEN};
                    else if (idx_reg == 6'd2)     byte_next = TS_POINTER;
                    else if (idx_reg == 6'd3)     byte_next = TS_FLAGS;
                    else                          byte_next = 8'd0;
                end
                KIND_PAD: begin
                    // counting bytes start at zero after type and length
                    if (idx_reg == 6'd1) byte_next = {2'b00, q_desc.len};
                    else                 byte_next = {2'b00, idx_reg - 6'd2};
                end
                default: byte_next = 8'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 6'd0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
            idx_reg     <= last_next ? 6'd0 : idx_reg + 6'd1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= byte_next;
            last_reg   <= last_next;
            status_reg <= q_desc.status;
            len_reg    <= q_desc.len;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = byte_reg;
    assign m_last_byte     = last_reg;
    assign m_status        = status_reg;
    assign m_option_length = len_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_last_byte && m_option_length == 6'd0)
        else $error("error word must be last with zero length");
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_desc.one_shot |-> idx_reg < q_desc.len)
        else $error("byte index past option length");
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> idx_reg == 6'd0)
        else $error("index not cleared after last word");

endmodule

### hw/rtl/ip_option_field_generator.sv
// ---------------------------------------------------------------------------
// ip_option_field_generator
// Builds IPv4 option bytes (end-of-list, no-op, timestamp, padding) from a
// type request, one option byte per output word.
// ---------------------------------------------------------------------------
// channel   dir  handshake         payload
// s_*       in   s_valid/s_ready   option_byte, section_offset, space_left,
//                                  size_only
// m_*       out  m_valid/m_ready   out_byte, last_byte, status, option_length
//
// A request yields one word per cycle unless stalled: 36 words for timestamp,
// 2..6 for padding, 1 for single-byte options, errors and size-only requests.
// The emit sequencer's byte counter sets the rate; the two-entry queue lets
// requests be taken while the back end is busy. Synchronous active-low reset
// empties the queue and the output register. Stalls on m_ready hold the word.
module ip_option_field_generator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_option_byte,
    input  logic [5:0] s_section_offset,
    input  logic [5:0] s_space_left,
    input  logic       s_size_only,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_byte,
    output logic [1:0] m_status,
    output logic [5:0] m_option_length
);
    import iofg_pkg::*;

    logic  push, pop, q_ready, q_valid;
    desc_t push_desc, q_desc;

    iofg_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_option_byte    (s_option_byte),
        .s_section_offset (s_section_offset),
        .s_space_left     (s_space_left),
        .s_size_only      (s_size_only),
        .push             (push),
        .push_desc        (push_desc),
        .q_ready          (q_ready)
    );

    iofg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_desc    (q_desc)
    );

    iofg_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_desc          (q_desc),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_byte     (m_last_byte),
        .m_status        (m_status),
        .m_option_length (m_option_length)
    );

endmodule
